// File: design/ch_pkg.sv
package ch_pkg;

  localparam int FIELD_W             = 16;
  localparam int HEADING_W           = 15;
  localparam int DECL_W              = 15;
  localparam int ANGLE_FRAC_BITS_DEF = 6;
  localparam int CORDIC_STAGES_DEF   = 16;

  // cordic datapath
  localparam int ACC_FRAC  = 20;
  localparam int PRESCALE  = 14;
  localparam int ATAN_LEN  = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
  localparam int XY_W      = 32;
  localparam int Z_W       = 31;
  localparam int A_W       = 32;

  typedef logic signed [Z_W-1:0] angle_t;

  // atan(2^-i) in degrees, Q20
  function automatic angle_t atan_q20(input logic [ATAN_IDX_W-1:0] idx);
    angle_t r;
    case (idx)
      5'd0:    r = Z_W'(47185920);
      5'd1:    r = Z_W'(27855475);
      5'd2:    r = Z_W'(14718068);
      5'd3:    r = Z_W'(7471121);
      5'd4:    r = Z_W'(3750058);
      5'd5:    r = Z_W'(1876857);
      5'd6:    r = Z_W'(938658);
      5'd7:    r = Z_W'(469357);
      5'd8:    r = Z_W'(234682);
      5'd9:    r = Z_W'(117342);
      5'd10:   r = Z_W'(58671);
      5'd11:   r = Z_W'(29335);
      5'd12:   r = Z_W'(14668);
      5'd13:   r = Z_W'(7334);
      5'd14:   r = Z_W'(3667);
      5'd15:   r = Z_W'(1833);
      5'd16:   r = Z_W'(917);
      5'd17:   r = Z_W'(458);
      5'd18:   r = Z_W'(229);
      5'd19:   r = Z_W'(115);
      5'd20:   r = Z_W'(57);
      5'd21:   r = Z_W'(29);
      5'd22:   r = Z_W'(14);
      5'd23:   r = Z_W'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/ch_sample_if.sv
interface ch_sample_if import ch_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] field_x;
  logic signed [FIELD_W-1:0] field_y;

  modport source (output valid, field_x, field_y, input ready);
  modport sink   (input valid, field_x, field_y, output ready);
endinterface

// File: design/ch_heading_if.sv
interface ch_heading_if import ch_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [HEADING_W-1:0] heading;

  modport source (output valid, heading, input ready);
  modport sink   (input valid, heading, output ready);
endinterface

// File: design/compass_heading_core.sv
// Compass heading from one calibrated magnetometer sample.
//
// sample_i carries signed field_x / field_y; heading_o returns the azimuth
// atan2(y, x) plus the declination register, wrapped into 0..360 degrees,
// in units of 2^-ANGLE_FRAC_BITS degree. Each input transaction gives one
// output transaction, in order.
// decl_we_i / decl_wdata_i write the signed declination; write it only
// while the pipeline is empty.
// An input transaction passes through an input register, one register
// per CORDIC micro-rotation, a round/declination register and a wrap
// register that drives the output.
// Throughput: one transaction per cycle while heading_o.ready is high; the
// pipeline depth is set by the number of CORDIC micro-rotation stages.
// Reset clears all valid bits and sets the declination to zero.
// When the receiver stalls, the output register holds its result and
// items behind it keep advancing into empty stages; sample_i.ready drops
// only once every stage is full.
module compass_heading_core import ch_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    decl_we_i,
  input  logic signed [DECL_W-1:0] decl_wdata_i,
  ch_sample_if.sink               sample_i,
  ch_heading_if.source            heading_o
);

  localparam int S    = CORDIC_STAGES;
  localparam int RS   = S + 1;   // round / declination stage
  localparam int OS   = S + 2;   // output stage
  localparam int DROP = ACC_FRAC - ANGLE_FRAC_BITS;

  localparam logic signed [A_W-1:0] RND_HALF = A_W'(64'd1 << (DROP - 1));
  localparam logic signed [A_W-1:0] FULL_ANG = A_W'(360 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(180 * (2 ** ACC_FRAC));

  logic signed [DECL_W-1:0] decl_q;

  logic [0:OS] v_q;
  logic [0:OS] ld;

  logic signed [XY_W-1:0] x_q [0:S];
  logic signed [XY_W-1:0] y_q [0:S];
  angle_t                 z_q [0:S];
  logic        [0:RS-1]   zf_q;

  logic signed [A_W-1:0]     a_q;
  logic        [HEADING_W-1:0] heading_q;

  // declination register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q <= '0;
    end else if (decl_we_i) begin
      decl_q <= decl_wdata_i;
    end
  end

  // a stage loads when empty or when its content moves on
  assign ld[OS] = !v_q[OS] || heading_o.ready;
  for (genvar k = 0; k < OS; k++) begin : g_ld
    assign ld[k] = !v_q[k] || ld[k+1];
  end

  assign sample_i.ready  = ld[0];
  assign heading_o.valid = v_q[OS];
  assign heading_o.heading = heading_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= sample_i.valid;
      end
      for (int k = 1; k <= OS; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0: prescale and fold the left half plane
  logic signed [XY_W-1:0] xs, ys, x0_d, y0_d;
  angle_t                 z0_d;
  logic                   zf0_d;

  always_comb begin
    xs    = XY_W'(sample_i.field_x) <<< PRESCALE;
    ys    = XY_W'(sample_i.field_y) <<< PRESCALE;
    zf0_d = (sample_i.field_x == '0) && (sample_i.field_y == '0);
    if (xs[XY_W-1]) begin
      x0_d = -xs;
      y0_d = -ys;
      z0_d = ys[XY_W-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      x0_d = xs;
      y0_d = ys;
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      x_q[0]  <= x0_d;
      y_q[0]  <= y0_d;
      z_q[0]  <= z0_d;
      zf_q[0] <= zf0_d;
    end
  end

  // one micro-rotation per stage
  for (genvar k = 1; k <= S; k++) begin : g_cordic
    logic signed [XY_W-1:0] dx, dy, x_d, y_d;
    angle_t                 z_d;
    angle_t                 step;

    always_comb begin
      dx   = y_q[k-1] >>> (k - 1);
      dy   = x_q[k-1] >>> (k - 1);
      step = atan_q20(ATAN_IDX_W'(k - 1));
      if (!y_q[k-1][XY_W-1]) begin
        x_d = x_q[k-1] + dx;
        y_d = y_q[k-1] - dy;
        z_d = z_q[k-1] + step;
      end else begin
        x_d = x_q[k-1] - dx;
        y_d = y_q[k-1] + dy;
        z_d = z_q[k-1] - step;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        x_q[k] <= x_d;
        y_q[k] <= y_d;
        z_q[k] <= z_d;
        if (k < RS) begin
          zf_q[k] <= zf_q[k-1];
        end
      end
    end
  end

  // round to output resolution, add declination
  logic signed [A_W-1:0] rnd, a_d;

  always_comb begin
    rnd = (A_W'(z_q[S]) + RND_HALF) >>> DROP;
    a_d = (zf_q[S] ? '0 : rnd) + A_W'(decl_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld[RS]) begin
      a_q <= a_d;
    end
  end

  // wrap into 0..360 degrees
  logic signed [A_W-1:0] w1, wrap_d;

  always_comb begin
    w1 = a_q + FULL_ANG;
    if (a_q[A_W-1]) begin
      wrap_d = w1[A_W-1] ? (w1 + FULL_ANG) : w1;
    end else if (a_q > FULL_ANG) begin
      wrap_d = a_q - FULL_ANG;
    end else begin
      wrap_d = a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[OS]) begin
      heading_q <= wrap_d[HEADING_W-1:0];
    end
  end

  // folded vector always lies in the right half plane
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> !x_q[0][XY_W-1])
    else $error("x negative after half-plane fold");

  // input may only be taken during an output stall if some stage is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heading_o.valid && !heading_o.ready && sample_i.ready) |-> !(&v_q))
    else $error("input accepted with a full stalled pipeline");

  // heading never exceeds a full turn when a full turn fits the field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heading_o.valid && (FULL_ANG < A_W'(2 ** HEADING_W)))
      |-> (A_W'(heading_o.heading) <= FULL_ANG))
    else $error("heading beyond 360 degrees");

endmodule
